// File: sv/rwcq_pkg.sv
// rwcq_pkg: shared types and constants for the rect wall collision query unit.
// Used by the controller, the datapath, the top level and the checker.
package rwcq_pkg;

   localparam int MAX_WALLS_DEF   = 256;
   localparam int NEAR_MARGIN_DEF = 40;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      HD_N  = 4'd0,
      HD_NE = 4'd1,
      HD_E  = 4'd2,
      HD_SE = 4'd3,
      HD_S  = 4'd4,
      HD_SW = 4'd5,
      HD_W  = 4'd6,
      HD_NW = 4'd7
   } hd_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
   } wall_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic add;
      logic start_query;
      logic scan;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic rsp_full;
   } status_type;

endpackage

// File: sv/rwcq_ctrl.sv
// rwcq_ctrl: controller state machine of the wall collision query unit.
// Depends on rwcq_pkg for the opcode, command and status types.
module rwcq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   input  rwcq_pkg::status_type   status,
   output rwcq_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd             = '0;
      cmd.clear       = accept && (req_opcode == rwcq_pkg::OP_CLEAR);
      cmd.add         = accept && (req_opcode == rwcq_pkg::OP_ADD);
      cmd.start_query = accept && (req_opcode == rwcq_pkg::OP_QUERY);
      cmd.scan        = (state_ff == ST_SCAN);
      // result leaves only when the output register is free or being emptied
      cmd.finish      = (state_ff == ST_SCAN) && status.scan_done &&
                        (!status.rsp_full || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start_query) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cmd.finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// File: sv/rwcq_datapath.sv
// rwcq_datapath: wall memory, scan pointer, overlap tests and result register.
// Depends on rwcq_pkg; driven by rwcq_ctrl through cmd_type / status_type.
module rwcq_datapath #(
   parameter int MAX_WALLS   = rwcq_pkg::MAX_WALLS_DEF,
   parameter int NEAR_MARGIN = rwcq_pkg::NEAR_MARGIN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rwcq_pkg::cmd_type     cmd,
   output rwcq_pkg::status_type  status,
   input  logic signed [15:0]    req_rect_x,
   input  logic signed [15:0]    req_rect_y,
   input  logic [14:0]           req_rect_w,
   input  logic [14:0]           req_rect_h,
   input  logic [3:0]            req_heading,
   input  logic [11:0]           req_step,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_allowed,
   output logic [2:0]            rsp_granted_heading
);

   localparam int CNTW = $clog2(MAX_WALLS + 1);
   localparam int AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
   // widest edge sum: full x span plus both margins plus the largest step
   localparam int SPAN = 65535 + 2 * NEAR_MARGIN + 4095;
   localparam int CW   = $clog2(SPAN + 1) + 2;
   localparam logic signed [CW-1:0] MARG = CW'(NEAR_MARGIN);

   rwcq_pkg::wall_type mem [MAX_WALLS];
   rwcq_pkg::wall_type rd_data_ff;
   logic               rd_vld_ff, rd_vld_in;
   logic [CNTW-1:0]    count_ff, count_in;
   logic [CNTW-1:0]    idx_ff, idx_in;
   logic               issue;
   logic               wr_en;

   // query box edges, half-open intervals [lo, hi)
   logic signed [CW-1:0] nx0_ff, nx1_ff, ny0_ff, ny1_ff;
   logic signed [CW-1:0] vx0_ff, vx1_ff, vy0_ff, vy1_ff;
   logic signed [CW-1:0] hx0_ff, hx1_ff, hy0_ff, hy1_ff;
   logic                 near_ok_ff, act_ok_ff;
   logic                 vneg_ff, hpos_ff;
   logic [3:0]           hd_ff;
   logic                 vblk_ff, vblk_in, hblk_ff, hblk_in;

   logic signed [CW-1:0] ax, ay, aw, ah, st, vd, hd;
   logic                 vneg, hpos;

   logic signed [CW-1:0] wx0, wx1, wy0, wy1;
   logic                 wall_ok, near_hit, v_hit, h_hit;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 allowed_ff;
   logic [2:0]           grant_ff;
   logic                 res_ok;
   logic [2:0]           res_grant;

   // ---- table fill ----
   assign wr_en = cmd.add && (count_ff < CNTW'(MAX_WALLS));

   always_comb begin
      count_in = count_ff;
      if (cmd.clear)  count_in = '0;
      else if (wr_en) count_in = count_ff + CNTW'(1);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= '{x: req_rect_x, y: req_rect_y,
                                    w: req_rect_w, h: req_rect_h};
      end
      if (issue) rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   // ---- scan pointer ----
   assign issue     = cmd.scan && (idx_ff < count_ff);
   assign rd_vld_in = issue;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.start_query) idx_in = '0;
      else if (issue)      idx_in = idx_ff + CNTW'(1);
   end

   assign status.scan_done = (idx_ff == count_ff) && !rd_vld_ff;
   assign status.rsp_full  = rsp_valid_ff;

   // ---- query latch ----
   always_comb begin
      ax   = CW'(req_rect_x);
      ay   = CW'(req_rect_y);
      aw   = CW'(req_rect_w);
      ah   = CW'(req_rect_h);
      st   = CW'(req_step);
      vneg = (req_heading == rwcq_pkg::HD_N) || (req_heading == rwcq_pkg::HD_NE) ||
             (req_heading == rwcq_pkg::HD_NW);
      hpos = (req_heading == rwcq_pkg::HD_NE) || (req_heading == rwcq_pkg::HD_E) ||
             (req_heading == rwcq_pkg::HD_SE);
      vd   = vneg ? -st : st;
      hd   = hpos ? st : -st;
   end

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         nx0_ff     <= ax - MARG;
         nx1_ff     <= ax + aw + MARG;
         ny0_ff     <= ay - MARG;
         ny1_ff     <= ay + ah + MARG;
         vx0_ff     <= ax;
         vx1_ff     <= ax + aw;
         vy0_ff     <= ay + vd;
         vy1_ff     <= ay + vd + ah;
         hx0_ff     <= ax + hd;
         hx1_ff     <= ax + hd + aw;
         hy0_ff     <= ay;
         hy1_ff     <= ay + ah;
         near_ok_ff <= ((aw + MARG + MARG) > 0) && ((ah + MARG + MARG) > 0);
         act_ok_ff  <= (req_rect_w != '0) && (req_rect_h != '0);
         vneg_ff    <= vneg;
         hpos_ff    <= hpos;
         hd_ff      <= req_heading;
      end
   end

   // ---- per-wall overlap tests ----
   always_comb begin
      wx0      = CW'($signed(rd_data_ff.x));
      wy0      = CW'($signed(rd_data_ff.y));
      wx1      = wx0 + CW'(rd_data_ff.w);
      wy1      = wy0 + CW'(rd_data_ff.h);
      wall_ok  = (rd_data_ff.w != '0) && (rd_data_ff.h != '0);
      near_hit = wall_ok && near_ok_ff && (nx0_ff < wx1) && (wx0 < nx1_ff) &&
                 (ny0_ff < wy1) && (wy0 < ny1_ff);
      v_hit    = wall_ok && act_ok_ff && (vx0_ff < wx1) && (wx0 < vx1_ff) &&
                 (vy0_ff < wy1) && (wy0 < vy1_ff);
      h_hit    = wall_ok && act_ok_ff && (hx0_ff < wx1) && (wx0 < hx1_ff) &&
                 (hy0_ff < wy1) && (wy0 < hy1_ff);
   end

   always_comb begin
      vblk_in = vblk_ff;
      hblk_in = hblk_ff;
      if (cmd.start_query) begin
         vblk_in = 1'b0;
         hblk_in = 1'b0;
      end else if (rd_vld_ff) begin
         vblk_in = vblk_ff || (near_hit && v_hit);
         hblk_in = hblk_ff || (near_hit && h_hit);
      end
   end

   // ---- direction resolution ----
   always_comb begin
      res_ok    = 1'b0;
      res_grant = 3'(rwcq_pkg::HD_N);
      unique case (hd_ff)
         rwcq_pkg::HD_N, rwcq_pkg::HD_S: begin
            res_ok    = !vblk_ff;
            res_grant = hd_ff[2:0];
         end
         rwcq_pkg::HD_E, rwcq_pkg::HD_W: begin
            res_ok    = !hblk_ff;
            res_grant = hd_ff[2:0];
         end
         rwcq_pkg::HD_NE, rwcq_pkg::HD_SE, rwcq_pkg::HD_SW, rwcq_pkg::HD_NW: begin
            priority if (!vblk_ff && !hblk_ff) begin
               res_ok    = 1'b1;
               res_grant = hd_ff[2:0];
            end else if (!vblk_ff) begin
               res_ok    = 1'b1;
               res_grant = vneg_ff ? 3'(rwcq_pkg::HD_N) : 3'(rwcq_pkg::HD_S);
            end else if (!hblk_ff) begin
               res_ok    = 1'b1;
               res_grant = hpos_ff ? 3'(rwcq_pkg::HD_E) : 3'(rwcq_pkg::HD_W);
            end else begin
               res_ok    = 1'b0;
            end
         end
         default: res_ok = 1'b0;
      endcase
      if (!res_ok) res_grant = 3'(rwcq_pkg::HD_N);
   end

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         allowed_ff <= res_ok;
         grant_ff   <= res_grant;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allowed         = allowed_ff;
   assign rsp_granted_heading = grant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         vblk_ff      <= 1'b0;
         hblk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         vblk_ff      <= vblk_in;
         hblk_ff      <= hblk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/rect_wall_collision_query_unit.sv
// A query beat scans every stored wall, one per cycle, through the single wall memory read
// port. Its result is registered once the last wall has been tested, or later while an
// earlier result still waits. A new query is not accepted until that result is registered;
// ready is low while scanning. A waiting result does not block clear or add beats.
// Synchronous active-high reset zeroes the wall count and drops rsp_valid; memory is kept.
module rect_wall_collision_query_unit #(
   parameter int MAX_WALLS   = rwcq_pkg::MAX_WALLS_DEF,
   parameter int NEAR_MARGIN = rwcq_pkg::NEAR_MARGIN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_rect_x,
   input  logic signed [15:0] req_rect_y,
   input  logic [14:0]        req_rect_w,
   input  logic [14:0]        req_rect_h,
   input  logic [3:0]         req_heading,
   input  logic [11:0]        req_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_allowed,
   output logic [2:0]         rsp_granted_heading
);

   rwcq_pkg::cmd_type    cmd;
   rwcq_pkg::status_type status;

   rwcq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   rwcq_datapath #(
      .MAX_WALLS   (MAX_WALLS),
      .NEAR_MARGIN (NEAR_MARGIN)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_rect_x          (req_rect_x),
      .req_rect_y          (req_rect_y),
      .req_rect_w          (req_rect_w),
      .req_rect_h          (req_rect_h),
      .req_heading         (req_heading),
      .req_step            (req_step),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_allowed         (rsp_allowed),
      .rsp_granted_heading (rsp_granted_heading)
   );

endmodule

// File: sv/rwcq_checker.sv
// rwcq_checker: port-level assertions for rect_wall_collision_query_unit.
// Depends on rwcq_pkg; attached to the top level by the bind below.
module rwcq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_opcode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_allowed,
   input logic [2:0]         rsp_granted_heading
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allowed) &&
                                  $stable(rsp_granted_heading))
      else $error("result beat changed while stalled");

   // a refusal always reports north
   a_refuse_north: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_allowed |-> rsp_granted_heading == 3'(rwcq_pkg::HD_N))
      else $error("refused result with non-north heading");

   // after a query beat the unit is busy scanning
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == rwcq_pkg::OP_QUERY |=> !req_ready)
      else $error("ready high right after a query beat");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("unit not idle after reset");

endmodule

bind rect_wall_collision_query_unit rwcq_checker u_rwcq_checker (.*);
